>>> rtl/core/isaac_keystream_xor_unit_macros.svh
// Assertion helpers used by the checker file.
`ifndef ISAAC_KEYSTREAM_XOR_UNIT_MACROS_SVH
`define ISAAC_KEYSTREAM_XOR_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define IKX_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ikx check failed");

// Next-cycle implication, disabled during reset
`define IKX_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ikx check failed");

`endif

>>> rtl/core/ikx_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ikx_pkg;

  localparam int STORE_WORDS = 256;
  localparam int IDX_W       = $clog2(STORE_WORDS);
  localparam int HALF_WORDS  = STORE_WORDS / 2;
  localparam int WORD_W      = 32;
  localparam int CNT_W       = 3;

  // Refresh shift pattern
  localparam int SH_0 = 13;
  localparam int SH_1 = 6;
  localparam int SH_2 = 2;
  localparam int SH_3 = 16;

  localparam logic [CNT_W-1:0] MAX_BYTES = 3'd4;

  // Command codes
  localparam logic [1:0] CMD_XOR         = 2'd0;
  localparam logic [1:0] CMD_LOAD_MIX    = 2'd1;
  localparam logic [1:0] CMD_LOAD_RES    = 2'd2;
  localparam logic [1:0] CMD_LOAD_SCALAR = 2'd3;

  // Scalar selectors for a scalar load
  localparam logic [IDX_W-1:0] SEL_ACC_A = 8'd0;
  localparam logic [IDX_W-1:0] SEL_ACC_B = 8'd1;
  localparam logic [IDX_W-1:0] SEL_ROUND = 8'd2;
  localparam logic [IDX_W-1:0] SEL_INDEX = 8'd3;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [IDX_W-1:0]  load_index;
    logic [WORD_W-1:0] load_value;
    logic [WORD_W-1:0] data_word;
    logic [CNT_W-1:0]  byte_count;
  } in_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] out_word;
    logic [CNT_W-1:0]  out_bytes;
    logic [WORD_W-1:0] key_word;
  } out_item_t;

endpackage
`default_nettype wire

>>> rtl/core/isaac_keystream_xor_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Handshake            Payload
// in_       input      in_valid / in_stall  ikx_pkg::in_item_t (cmd, load, data, count)
// out_      output     out_valid/out_stall  ikx_pkg::out_item_t (word, bytes, key)
//
// Load commands and ignored items leave the unit idle.
// A data item goes through transfer, then key fetch from the result store.
// The data item that uses word 255 adds a refresh that stalls the input; each entry goes
// through half-offset read, indirect read, mix write, index read and result write.
// rst_n clears the scalars, the read index and the control; the stores are not cleared.
// A waiting result holds the next data item in the key fetch, which stalls all input.
module isaac_keystream_xor_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ikx_pkg::in_item_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output ikx_pkg::out_item_t out_data
);

  typedef enum logic [6:0] {
    ST_IDLE    = 7'b0000001,
    ST_KEY     = 7'b0000010,
    ST_RD_HALF = 7'b0000100,
    ST_RD_IND  = 7'b0001000,
    ST_WR_MIX  = 7'b0010000,
    ST_RD_NV   = 7'b0100000,
    ST_WR_RES  = 7'b1000000
  } state_t;

  localparam logic [ikx_pkg::IDX_W-1:0] LAST_IDX  = ikx_pkg::IDX_W'(ikx_pkg::STORE_WORDS - 1);
  localparam logic [ikx_pkg::IDX_W-1:0] HALF_OFFS = ikx_pkg::IDX_W'(ikx_pkg::HALF_WORDS);

  state_t state_r, state_nxt;

  logic [ikx_pkg::WORD_W-1:0] acc_a_r;
  logic [ikx_pkg::WORD_W-1:0] acc_b_r;
  logic [ikx_pkg::WORD_W-1:0] round_r;
  logic [ikx_pkg::IDX_W-1:0]  idx_r;
  logic [ikx_pkg::IDX_W-1:0]  k_r;
  logic [ikx_pkg::WORD_W-1:0] old_r;
  logic [ikx_pkg::IDX_W-1:0]  nv_idx_r;
  logic [ikx_pkg::WORD_W-1:0] data_r;
  logic [ikx_pkg::CNT_W-1:0]  cnt_r;
  logic                       out_valid_r;
  ikx_pkg::out_item_t         out_r;

  // Stores
  logic [ikx_pkg::WORD_W-1:0] mix_mem [ikx_pkg::STORE_WORDS];
  logic [ikx_pkg::WORD_W-1:0] res_mem [ikx_pkg::STORE_WORDS];
  logic [ikx_pkg::WORD_W-1:0] mix_rdata_r;
  logic [ikx_pkg::WORD_W-1:0] res_rdata_r;

  logic                       mix_we, res_we;
  logic [ikx_pkg::IDX_W-1:0]  mix_waddr, res_waddr, mix_raddr;
  logic [ikx_pkg::WORD_W-1:0] mix_wdata, res_wdata;

  logic                       in_xfer, out_free, key_xfer, refresh_go, xor_item;
  logic [ikx_pkg::CNT_W-1:0]  cnt_sat;
  logic [ikx_pkg::WORD_W-1:0] sh, a_new, nv, b_new;

  function automatic logic [ikx_pkg::WORD_W-1:0] byte_mask(input logic [ikx_pkg::CNT_W-1:0] n);
    logic [ikx_pkg::WORD_W-1:0] m;
    case (n)
      3'd1:    m = 32'h0000_00FF;
      3'd2:    m = 32'h0000_FFFF;
      3'd3:    m = 32'h00FF_FFFF;
      default: m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

  // Handshake
  assign in_stall  = (state_r != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign key_xfer  = (state_r == ST_KEY) && out_free;
  assign refresh_go = key_xfer && (idx_r == LAST_IDX);
  assign xor_item  = in_xfer && (in_data.cmd == ikx_pkg::CMD_XOR) && (in_data.byte_count != '0);
  assign cnt_sat   = (in_data.byte_count > ikx_pkg::MAX_BYTES) ? ikx_pkg::MAX_BYTES
                                                               : in_data.byte_count;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Refresh datapath
  always_comb begin
    case (k_r[1:0])
      2'd0:    sh = acc_a_r << ikx_pkg::SH_0;
      2'd1:    sh = acc_a_r >> ikx_pkg::SH_1;
      2'd2:    sh = acc_a_r << ikx_pkg::SH_2;
      default: sh = acc_a_r >> ikx_pkg::SH_3;
    endcase
  end

  assign a_new = (acc_a_r ^ sh) + mix_rdata_r;
  assign nv    = mix_rdata_r + acc_a_r + acc_b_r;
  assign b_new = mix_rdata_r + old_r;

  // Mix store read address per refresh step
  always_comb begin
    case (state_r)
      ST_KEY:     mix_raddr = '0;
      ST_RD_HALF: mix_raddr = k_r + HALF_OFFS;
      ST_RD_IND:  mix_raddr = old_r[ikx_pkg::IDX_W+1:2];
      ST_RD_NV:   mix_raddr = nv_idx_r;
      ST_WR_RES:  mix_raddr = k_r + 1'b1;
      default:    mix_raddr = k_r;
    endcase
  end

  // Store write ports: loads while idle, refresh otherwise
  always_comb begin
    mix_we    = (state_r == ST_WR_MIX) ||
                (in_xfer && (in_data.cmd == ikx_pkg::CMD_LOAD_MIX));
    mix_waddr = (state_r == ST_WR_MIX) ? k_r : in_data.load_index;
    mix_wdata = (state_r == ST_WR_MIX) ? nv : in_data.load_value;
    res_we    = (state_r == ST_WR_RES) ||
                (in_xfer && (in_data.cmd == ikx_pkg::CMD_LOAD_RES));
    res_waddr = (state_r == ST_WR_RES) ? k_r : in_data.load_index;
    res_wdata = (state_r == ST_WR_RES) ? b_new : in_data.load_value;
  end

  always_ff @(posedge clk) begin
    if (mix_we) begin
      mix_mem[mix_waddr] <= mix_wdata;
    end
    mix_rdata_r <= mix_mem[mix_raddr];
  end

  always_ff @(posedge clk) begin
    if (res_we) begin
      res_mem[res_waddr] <= res_wdata;
    end
    res_rdata_r <= res_mem[idx_r];
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:    if (xor_item) state_nxt = ST_KEY;
      ST_KEY:     if (key_xfer) state_nxt = refresh_go ? ST_RD_HALF : ST_IDLE;
      ST_RD_HALF: state_nxt = ST_RD_IND;
      ST_RD_IND:  state_nxt = ST_WR_MIX;
      ST_WR_MIX:  state_nxt = ST_RD_NV;
      ST_RD_NV:   state_nxt = ST_WR_RES;
      ST_WR_RES:  state_nxt = (k_r == LAST_IDX) ? ST_IDLE : ST_RD_HALF;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // Control and scalar state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      acc_a_r     <= '0;
      acc_b_r     <= '0;
      round_r     <= '0;
      idx_r       <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // drop the result once taken
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      // scalar loads
      if (in_xfer && (in_data.cmd == ikx_pkg::CMD_LOAD_SCALAR)) begin
        case (in_data.load_index)
          ikx_pkg::SEL_ACC_A: acc_a_r <= in_data.load_value;
          ikx_pkg::SEL_ACC_B: acc_b_r <= in_data.load_value;
          ikx_pkg::SEL_ROUND: round_r <= in_data.load_value;
          ikx_pkg::SEL_INDEX: idx_r   <= in_data.load_value[ikx_pkg::IDX_W-1:0];
          default: ;
        endcase
      end
      // consume the key and advance the index
      if (key_xfer) begin
        out_valid_r <= 1'b1;
        idx_r       <= idx_r + 1'b1;
      end
      // open a refresh round
      if (refresh_go) begin
        round_r <= round_r + 1'b1;
        acc_b_r <= acc_b_r + round_r + 1'b1;
        k_r     <= '0;
      end
      if (state_r == ST_RD_IND) begin
        acc_a_r <= a_new;
      end
      if (state_r == ST_WR_RES) begin
        acc_b_r <= b_new;
        k_r     <= k_r + 1'b1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (xor_item) begin
      data_r <= in_data.data_word;
      cnt_r  <= cnt_sat;
    end
    if (key_xfer) begin
      out_r.out_word  <= (data_r ^ res_rdata_r) & byte_mask(cnt_r);
      out_r.out_bytes <= cnt_r;
      out_r.key_word  <= res_rdata_r;
    end
    if (state_r == ST_RD_HALF) begin
      old_r <= mix_rdata_r;
    end
    if (state_r == ST_WR_MIX) begin
      nv_idx_r <= nv[ikx_pkg::IDX_W+9:10];
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/ikx_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "isaac_keystream_xor_unit_macros.svh"
module ikx_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_stall,
  input wire ikx_pkg::in_item_t in_data,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire ikx_pkg::out_item_t out_data
);

  // hold a stalled result
  `IKX_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
  `IKX_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(out_data))

  // bytes above the count are zero
  `IKX_ASSERT_NOW(a_upper_zero, clk, rst_n, out_valid, (out_data.out_bytes == 3'd1 && out_data.out_word[31:8] == 24'd0) || (out_data.out_bytes == 3'd2 && out_data.out_word[31:16] == 16'd0) || (out_data.out_bytes == 3'd3 && out_data.out_word[31:24] == 8'd0) || (out_data.out_bytes == 3'd4))

  // a data transfer holds off the next item during the key fetch
  `IKX_ASSERT_NEXT(a_busy_after_xor, clk, rst_n, in_valid && !in_stall && in_data.cmd == ikx_pkg::CMD_XOR && in_data.byte_count != 3'd0, in_stall)

  // a new result comes only out of the key fetch
  `IKX_ASSERT_NOW(a_result_source, clk, rst_n, $rose(out_valid), $past(in_stall))

endmodule

bind isaac_keystream_xor_unit ikx_checker u_ikx_checker (.*);
`default_nettype wire
